[rtl/glsq_pkg.sv]
// Package for the game pad link sequencer: types, state and code constants, decode functions.
`default_nettype none

package glsq_pkg;

    // Link state numbers.
    localparam logic [4:0] ST_IDLE        = 5'd0;
    localparam logic [4:0] ST_SPEED_CHECK = 5'd1;
    localparam logic [4:0] ST_SLOW_INIT   = 5'd2;
    localparam logic [4:0] ST_SLOW_ENTER  = 5'd3;
    localparam logic [4:0] ST_SLOW_QUERY  = 5'd4;
    localparam logic [4:0] ST_SLOW_LOCK   = 5'd5;
    localparam logic [4:0] ST_SLOW_VIB0   = 5'd6;
    localparam logic [4:0] ST_SLOW_VIB1   = 5'd7;
    localparam logic [4:0] ST_SLOW_VIB2   = 5'd8;
    localparam logic [4:0] ST_SLOW_VIB3   = 5'd9;
    localparam logic [4:0] ST_SLOW_EXIT   = 5'd10;
    localparam logic [4:0] ST_DIGITAL     = 5'd11;
    localparam logic [4:0] ST_TWIST       = 5'd12;
    localparam logic [4:0] ST_ANALOG      = 5'd13;
    localparam logic [4:0] ST_FAST_INIT   = 5'd14;
    localparam logic [4:0] ST_FAST_ENTER  = 5'd15;
    localparam logic [4:0] ST_FAST_QUERY  = 5'd16;
    localparam logic [4:0] ST_FAST_LOCK   = 5'd17;
    localparam logic [4:0] ST_PRESS0      = 5'd18;
    localparam logic [4:0] ST_PRESS1      = 5'd19;
    localparam logic [4:0] ST_PRESS2      = 5'd20;
    localparam logic [4:0] ST_PRESS3      = 5'd21;
    localparam logic [4:0] ST_FAST_VIB0   = 5'd22;
    localparam logic [4:0] ST_FAST_VIB1   = 5'd23;
    localparam logic [4:0] ST_FAST_VIB2   = 5'd24;
    localparam logic [4:0] ST_FAST_VIB3   = 5'd25;
    localparam logic [4:0] ST_FAST_EXIT   = 5'd26;
    localparam logic [4:0] ST_FAST_TWIST  = 5'd27;
    localparam logic [4:0] ST_ANALOG2     = 5'd28;

    // Frame kinds.
    localparam logic [2:0] FRM_POLL     = 3'd0;
    localparam logic [2:0] FRM_ENTER    = 3'd1;
    localparam logic [2:0] FRM_QUERY    = 3'd2;
    localparam logic [2:0] FRM_LOCK     = 3'd3;
    localparam logic [2:0] FRM_VIB_MAP  = 3'd4;
    localparam logic [2:0] FRM_PRESSURE = 3'd5;
    localparam logic [2:0] FRM_EXIT     = 3'd6;
    localparam logic [2:0] FRM_MOTORS   = 3'd7;

    // Device kinds.
    localparam logic [2:0] DEV_NONE       = 3'd0;
    localparam logic [2:0] DEV_INIT       = 3'd1;
    localparam logic [2:0] DEV_DIGITAL    = 3'd2;
    localparam logic [2:0] DEV_TWIST      = 3'd3;
    localparam logic [2:0] DEV_ANALOG     = 3'd4;
    localparam logic [2:0] DEV_FAST_INIT  = 3'd5;
    localparam logic [2:0] DEV_FAST_TWIST = 3'd6;
    localparam logic [2:0] DEV_ANALOG2    = 3'd7;

    // Response bytes and words; the check byte is the high byte of a word.
    localparam logic [7:0]  READY_BYTE   = 8'h5a;
    localparam logic [7:0]  ID_TWIST     = 8'h23;
    localparam logic [15:0] WORD_QUERY   = 16'h5af3;
    localparam logic [15:0] WORD_FTWIST  = 16'h5aa5;
    localparam logic [15:0] WORD_DIGITAL = 16'h5a41;
    localparam logic [15:0] WORD_TWIST   = 16'h5a23;
    localparam logic [15:0] WORD_ANALOG  = 16'h5a73;
    localparam logic [15:0] WORD_ANALOG2 = 16'h5a79;

    typedef struct packed {
        logic [7:0] resp_id;
        logic [7:0] resp_check;
        logic       load_small;
        logic [7:0] small_power;
        logic [7:0] small_ticks;
        logic       load_large;
        logic [7:0] large_power;
        logic [7:0] large_ticks;
    } t_glsq_item;

    typedef struct packed {
        logic [4:0] seq;
        logic [2:0] device;
        logic [7:0] small_drive;
        logic [7:0] large_drive;
        logic [7:0] small_count;
        logic [7:0] large_count;
    } t_glsq_state;

    function automatic logic [2:0] device_of(input logic [4:0] s);
        logic [2:0] d;
        d = DEV_NONE;
        priority if (s == ST_IDLE)        d = DEV_NONE;
        else if (s <= ST_SLOW_EXIT)       d = DEV_INIT;
        else if (s == ST_DIGITAL)         d = DEV_DIGITAL;
        else if (s == ST_TWIST)           d = DEV_TWIST;
        else if (s == ST_ANALOG)          d = DEV_ANALOG;
        else if (s <= ST_FAST_EXIT)       d = DEV_FAST_INIT;
        else if (s == ST_FAST_TWIST)      d = DEV_FAST_TWIST;
        else if (s == ST_ANALOG2)         d = DEV_ANALOG2;
        else                              d = DEV_NONE;
        return d;
    endfunction

    function automatic logic [2:0] frame_of(input logic [4:0] s);
        logic [2:0] f;
        f = FRM_POLL;
        unique case (s)
            ST_SLOW_ENTER, ST_FAST_ENTER: f = FRM_ENTER;
            ST_SLOW_QUERY, ST_FAST_QUERY: f = FRM_QUERY;
            ST_SLOW_LOCK, ST_FAST_LOCK:   f = FRM_LOCK;
            ST_SLOW_VIB0, ST_SLOW_VIB1, ST_SLOW_VIB2, ST_SLOW_VIB3,
            ST_FAST_VIB0, ST_FAST_VIB1, ST_FAST_VIB2, ST_FAST_VIB3: f = FRM_VIB_MAP;
            ST_PRESS0, ST_PRESS1, ST_PRESS2, ST_PRESS3: f = FRM_PRESSURE;
            ST_SLOW_EXIT, ST_FAST_EXIT:   f = FRM_EXIT;
            ST_ANALOG, ST_ANALOG2:        f = FRM_MOTORS;
            default:                      f = FRM_POLL;
        endcase
        return f;
    endfunction

    function automatic logic fast_of(input logic [4:0] s);
        return (s == ST_SPEED_CHECK) || ((s >= ST_FAST_INIT) && (s <= ST_ANALOG2));
    endfunction

endpackage

`default_nettype wire

[rtl/glsq_step.sv]
// Next-state logic of the link sequencer and the motor drive countdown for one response item.
`default_nettype none

module glsq_step
    import glsq_pkg::*;
(
    input  wire t_glsq_state i_cur,
    input  wire t_glsq_item  i_item,
    output t_glsq_state      o_nxt
);

    logic        ok;
    logic [15:0] word;
    logic        fail;
    logic [4:0]  seq_next;
    logic [7:0]  small_drive_l;
    logic [7:0]  small_count_l;
    logic [7:0]  large_drive_l;
    logic [7:0]  large_count_l;

    assign ok   = (i_item.resp_check == READY_BYTE);
    assign word = {i_item.resp_check, i_item.resp_id};

    always_comb begin
        fail     = 1'b0;
        seq_next = ST_IDLE;
        unique case (i_cur.seq)
            ST_IDLE: begin
                seq_next = ST_SPEED_CHECK;
                fail     = !ok;
            end
            ST_SPEED_CHECK: seq_next = ok ? ST_FAST_INIT : ST_SLOW_INIT;
            ST_SLOW_INIT: begin
                seq_next = (i_item.resp_id == ID_TWIST) ? ST_TWIST : ST_SLOW_ENTER;
                fail     = !ok;
            end
            ST_SLOW_ENTER: seq_next = ok ? ST_SLOW_QUERY : ST_DIGITAL;
            ST_SLOW_QUERY: seq_next = (word == WORD_QUERY) ? ST_SLOW_LOCK : ST_DIGITAL;
            ST_SLOW_LOCK, ST_SLOW_VIB0, ST_SLOW_VIB1, ST_SLOW_VIB2, ST_SLOW_VIB3,
            ST_FAST_LOCK, ST_PRESS0, ST_PRESS1, ST_PRESS2, ST_PRESS3,
            ST_FAST_VIB0, ST_FAST_VIB1, ST_FAST_VIB2, ST_FAST_VIB3: begin
                seq_next = i_cur.seq + 5'd1;
                fail     = !ok;
            end
            ST_SLOW_EXIT: begin
                seq_next = ST_ANALOG;
                fail     = !ok;
            end
            ST_DIGITAL: begin
                seq_next = ST_DIGITAL;
                fail     = (word != WORD_DIGITAL);
            end
            ST_TWIST: begin
                seq_next = ST_TWIST;
                fail     = (word != WORD_TWIST);
            end
            ST_ANALOG: begin
                seq_next = ST_ANALOG;
                fail     = (word != WORD_ANALOG);
            end
            ST_FAST_INIT: begin
                seq_next = ST_FAST_ENTER;
                fail     = !ok;
            end
            ST_FAST_ENTER: seq_next = ok ? ST_FAST_QUERY : ST_DIGITAL;
            ST_FAST_QUERY: begin
                priority if (word == WORD_QUERY)  seq_next = ST_FAST_LOCK;
                else if (word == WORD_FTWIST)     seq_next = ST_FAST_TWIST;
                else                              seq_next = ST_DIGITAL;
            end
            ST_FAST_EXIT: begin
                seq_next = ST_ANALOG2;
                fail     = !ok;
            end
            ST_FAST_TWIST: begin
                seq_next = ST_FAST_TWIST;
                fail     = (word != WORD_FTWIST);
            end
            ST_ANALOG2: begin
                seq_next = ST_ANALOG2;
                fail     = (word != WORD_ANALOG2);
            end
            default: begin
                seq_next = ST_IDLE;
                fail     = 1'b1;
            end
        endcase
    end

    assign small_drive_l = i_item.load_small ? i_item.small_power : i_cur.small_drive;
    assign small_count_l = i_item.load_small ? i_item.small_ticks : i_cur.small_count;
    assign large_drive_l = i_item.load_large ? i_item.large_power : i_cur.large_drive;
    assign large_count_l = i_item.load_large ? i_item.large_ticks : i_cur.large_count;

    always_comb begin
        o_nxt.seq    = fail ? ST_IDLE : seq_next;
        o_nxt.device = fail ? DEV_NONE : device_of(i_cur.seq);
        if (small_count_l != 8'd0) begin
            o_nxt.small_count = small_count_l - 8'd1;
            o_nxt.small_drive = small_drive_l;
        end else begin
            o_nxt.small_count = 8'd0;
            o_nxt.small_drive = 8'd0;
        end
        if (large_count_l != 8'd0) begin
            o_nxt.large_count = large_count_l - 8'd1;
            o_nxt.large_drive = large_drive_l;
        end else begin
            o_nxt.large_count = 8'd0;
            o_nxt.large_drive = 8'd0;
        end
    end

endmodule

`default_nettype wire

[rtl/game_pad_link_sequencer_top.sv]
// Top level of the game pad link sequencer: input register, link state and result port.
`default_nettype none

// Each input item is the pad's reply to one frame; the block answers with exactly one
// result item that names the next frame, its bit clock, the detected device and the
// motor bytes. An item is taken into an input register and, once the result slot is free,
// resolved by one pass of the next-state logic into the link state registers, which also
// hold the result until it is taken. One item per clock cycle is sustained while the
// result port is ready; a stalled result port holds at most one more item in the input
// register before the input side stalls too.
module game_pad_link_sequencer_top
    import glsq_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // resp_id, resp_check, small_power, small_ticks, large_power, large_ticks
    input  wire  [47:0] s_axis_tdata,
    // load_small, load_large
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // frame_kind, high_speed, device_kind, link_state, motor_small_out,
    // motor_large_out, zero fill
    output logic [31:0] m_axis_tdata
);

    logic        r_in_valid;
    logic        n_in_valid;
    t_glsq_item  r_in_item;
    logic        r_out_valid;
    logic        n_out_valid;
    t_glsq_state r_state;
    t_glsq_state n_state;
    logic        advance;
    logic        in_take;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign n_in_valid  = in_take || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && !m_axis_tready);

    glsq_step u_step (
        .i_cur  (r_state),
        .i_item (r_in_item),
        .o_nxt  (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.resp_id     <= s_axis_tdata[7:0];
            r_in_item.resp_check  <= s_axis_tdata[15:8];
            r_in_item.load_small  <= s_axis_tuser[0];
            r_in_item.small_power <= s_axis_tdata[23:16];
            r_in_item.small_ticks <= s_axis_tdata[31:24];
            r_in_item.load_large  <= s_axis_tuser[1];
            r_in_item.large_power <= s_axis_tdata[39:32];
            r_in_item.large_ticks <= s_axis_tdata[47:40];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_state.large_drive, r_state.small_drive, r_state.seq,
                            r_state.device, fast_of(r_state.seq), frame_of(r_state.seq)};

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.seq <= ST_ANALOG2)
        else $error("Link state left the defined range.");

    a_idle_no_device: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.seq == ST_IDLE |-> r_state.device == DEV_NONE)
        else $error("Idle link state reports a device.");

    a_held_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_item))
        else $error("A waiting input item was lost or changed.");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> $stable(r_state))
        else $error("Link state changed while its result was waiting.");

endmodule

`default_nettype wire

[test/tb_game_pad_link_sequencer_top.sv]
// Self-checking testbench for the game pad link sequencer with stream handshakes on both sides.
`timescale 1ns / 1ps

module tb_game_pad_link_sequencer_top;
    import glsq_pkg::*;

    localparam int          RANDOM_ITEMS = 1725;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          HOLD_AT      = 400;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          PAUSE_AT     = 1000;
    localparam logic [5:0]  LINK_FAIL    = 6'd32;

    typedef struct packed {
        logic [2:0] frame;
        logic       fast;
        logic [2:0] dev;
        logic [4:0] seq;
        logic [7:0] motor_small;
        logic [7:0] motor_large;
    } t_link_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    t_glsq_item  pending_items[$];
    t_link_reply expected_replies[$];
    int          total_items = 0;
    int          issued = 0;
    int          taken = 0;
    int          replies_due = 0;
    int          replies_seen = 0;
    int          errors = 0;
    int          stall_cycles = 0;

    // Sequencer copy used while building the stimulus.
    logic [4:0]  plan_seq = ST_IDLE;

    // Predicted block state.
    logic [4:0]  link_seq = ST_IDLE;
    logic [2:0]  pad_dev = DEV_NONE;
    logic [7:0]  drv_small = '0;
    logic [7:0]  drv_large = '0;
    logic [7:0]  cnt_small = '0;
    logic [7:0]  cnt_large = '0;
    logic [31:0] states_seen = '0;

    int          tx_gap = 0;
    bit          tx_burst = 1'b0;
    int          rx_wait = 0;
    int          rx_seen = 0;
    bit          rx_burst = 1'b0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    game_pad_link_sequencer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [2:0] pad_class(input logic [4:0] s);
        case (s)
            ST_SPEED_CHECK, ST_SLOW_INIT, ST_SLOW_ENTER, ST_SLOW_QUERY, ST_SLOW_LOCK,
            ST_SLOW_VIB0, ST_SLOW_VIB1, ST_SLOW_VIB2, ST_SLOW_VIB3, ST_SLOW_EXIT:
                return DEV_INIT;
            ST_DIGITAL:    return DEV_DIGITAL;
            ST_TWIST:      return DEV_TWIST;
            ST_ANALOG:     return DEV_ANALOG;
            ST_FAST_INIT, ST_FAST_ENTER, ST_FAST_QUERY, ST_FAST_LOCK,
            ST_PRESS0, ST_PRESS1, ST_PRESS2, ST_PRESS3,
            ST_FAST_VIB0, ST_FAST_VIB1, ST_FAST_VIB2, ST_FAST_VIB3, ST_FAST_EXIT:
                return DEV_FAST_INIT;
            ST_FAST_TWIST: return DEV_FAST_TWIST;
            ST_ANALOG2:    return DEV_ANALOG2;
            default:       return DEV_NONE;
        endcase
    endfunction

    function automatic logic [2:0] frame_after(input logic [4:0] s);
        case (s)
            ST_SLOW_ENTER, ST_FAST_ENTER: return FRM_ENTER;
            ST_SLOW_QUERY, ST_FAST_QUERY: return FRM_QUERY;
            ST_SLOW_LOCK, ST_FAST_LOCK:   return FRM_LOCK;
            ST_SLOW_VIB0, ST_SLOW_VIB1, ST_SLOW_VIB2, ST_SLOW_VIB3,
            ST_FAST_VIB0, ST_FAST_VIB1, ST_FAST_VIB2, ST_FAST_VIB3:
                return FRM_VIB_MAP;
            ST_PRESS0, ST_PRESS1, ST_PRESS2, ST_PRESS3: return FRM_PRESSURE;
            ST_SLOW_EXIT, ST_FAST_EXIT:   return FRM_EXIT;
            ST_ANALOG, ST_ANALOG2:        return FRM_MOTORS;
            default:                      return FRM_POLL;
        endcase
    endfunction

    function automatic logic clock_is_fast(input logic [4:0] s);
        return (s == ST_SPEED_CHECK) || (s >= ST_FAST_INIT && s <= ST_ANALOG2);
    endfunction

    function automatic logic [5:0] link_next(input logic [4:0] s, input logic [7:0] id,
                                             input logic [7:0] chk);
        logic        ok;
        logic [15:0] word;
        logic [5:0]  n;
        ok = (chk == READY_BYTE);
        word = {chk, id};
        case (s)
            ST_IDLE:        n = ok ? ST_SPEED_CHECK : LINK_FAIL;
            ST_SPEED_CHECK: n = ok ? ST_FAST_INIT : ST_SLOW_INIT;
            ST_SLOW_INIT:   n = !ok ? LINK_FAIL : (id == ID_TWIST) ? ST_TWIST : ST_SLOW_ENTER;
            ST_SLOW_ENTER:  n = ok ? ST_SLOW_QUERY : ST_DIGITAL;
            ST_SLOW_QUERY:  n = (word == WORD_QUERY) ? ST_SLOW_LOCK : ST_DIGITAL;
            ST_SLOW_LOCK, ST_SLOW_VIB0, ST_SLOW_VIB1, ST_SLOW_VIB2, ST_SLOW_VIB3:
                n = ok ? {1'b0, s} + 6'd1 : LINK_FAIL;
            ST_SLOW_EXIT:   n = ok ? ST_ANALOG : LINK_FAIL;
            ST_DIGITAL:     n = (word == WORD_DIGITAL) ? ST_DIGITAL : LINK_FAIL;
            ST_TWIST:       n = (word == WORD_TWIST) ? ST_TWIST : LINK_FAIL;
            ST_ANALOG:      n = (word == WORD_ANALOG) ? ST_ANALOG : LINK_FAIL;
            ST_FAST_INIT:   n = ok ? ST_FAST_ENTER : LINK_FAIL;
            ST_FAST_ENTER:  n = ok ? ST_FAST_QUERY : ST_DIGITAL;
            ST_FAST_QUERY:  n = (word == WORD_QUERY) ? ST_FAST_LOCK :
                                (word == WORD_FTWIST) ? ST_FAST_TWIST : ST_DIGITAL;
            ST_FAST_LOCK, ST_PRESS0, ST_PRESS1, ST_PRESS2, ST_PRESS3,
            ST_FAST_VIB0, ST_FAST_VIB1, ST_FAST_VIB2, ST_FAST_VIB3:
                n = ok ? {1'b0, s} + 6'd1 : LINK_FAIL;
            ST_FAST_EXIT:   n = ok ? ST_ANALOG2 : LINK_FAIL;
            ST_FAST_TWIST:  n = (word == WORD_FTWIST) ? ST_FAST_TWIST : LINK_FAIL;
            ST_ANALOG2:     n = (word == WORD_ANALOG2) ? ST_ANALOG2 : LINK_FAIL;
            default:        n = LINK_FAIL;
        endcase
        return n;
    endfunction

    task automatic predict_reply(input t_glsq_item it);
        logic [5:0]  nxt;
        t_link_reply r;
        if (it.load_small) begin
            drv_small = it.small_power;
            cnt_small = it.small_ticks;
        end
        if (it.load_large) begin
            drv_large = it.large_power;
            cnt_large = it.large_ticks;
        end
        nxt = link_next(link_seq, it.resp_id, it.resp_check);
        if (nxt == LINK_FAIL) begin
            link_seq = ST_IDLE;
            pad_dev = DEV_NONE;
        end else begin
            pad_dev = pad_class(link_seq);
            link_seq = nxt[4:0];
        end
        if (cnt_small != 0) cnt_small = cnt_small - 8'd1;
        else drv_small = '0;
        if (cnt_large != 0) cnt_large = cnt_large - 8'd1;
        else drv_large = '0;
        r.frame = frame_after(link_seq);
        r.fast = clock_is_fast(link_seq);
        r.dev = pad_dev;
        r.seq = link_seq;
        r.motor_small = drv_small;
        r.motor_large = drv_large;
        states_seen[link_seq] = 1'b1;
        expected_replies.push_back(r);
        replies_due++;
    endtask

    function automatic t_glsq_item reply_item(input logic [7:0] id, input logic [7:0] chk);
        t_glsq_item it;
        it = '0;
        it.resp_id = id;
        it.resp_check = chk;
        return it;
    endfunction

    task automatic enqueue_reply(input t_glsq_item it);
        logic [5:0] nxt;
        pending_items.push_back(it);
        total_items++;
        nxt = link_next(plan_seq, it.resp_id, it.resp_check);
        plan_seq = (nxt == LINK_FAIL) ? ST_IDLE : nxt[4:0];
    endtask

    // Mostly the reply that moves the link deeper, with near misses and noise mixed in.
    task automatic pick_reply(input logic [4:0] s, output logic [7:0] id, output logic [7:0] chk);
        logic [15:0] word;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        word = {READY_BYTE, 8'($urandom)};
        if (roll < 8) begin
            word = 16'($urandom);
        end else begin
            case (s)
                ST_SPEED_CHECK, ST_SLOW_ENTER, ST_FAST_ENTER: begin
                    if (roll < ((s == ST_SPEED_CHECK) ? 54 : 24)) begin
                        word[15:8] = 8'($urandom);
                        if (word[15:8] == READY_BYTE) word[15:8] = 8'hff;
                    end
                end
                ST_SLOW_INIT:  if (roll < 50) word[7:0] = ID_TWIST;
                ST_SLOW_QUERY: if (roll >= 25) word = WORD_QUERY;
                ST_FAST_QUERY: begin
                    if (roll >= 55) word = WORD_QUERY;
                    else if (roll >= 20) word = WORD_FTWIST;
                end
                ST_DIGITAL:    if (roll >= 14) word = WORD_DIGITAL;
                ST_TWIST:      if (roll >= 14) word = WORD_TWIST;
                ST_ANALOG:     if (roll >= 14) word = WORD_ANALOG;
                ST_FAST_TWIST: if (roll >= 14) word = WORD_FTWIST;
                ST_ANALOG2:    if (roll >= 14) word = WORD_ANALOG2;
                default: ;
            endcase
        end
        chk = word[15:8];
        id = word[7:0];
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Driver.
    always @(negedge i_clk) begin
        logic       nv;
        t_glsq_item it;
        nv = s_axis_tvalid;
        if (nv && taken == issued) begin
            nv = 1'b0;
            if (issued % 64 == 0) tx_burst = ($urandom_range(0, 3) == 0);
            tx_gap = tx_burst ? 0 : $urandom_range(0, 3);
        end
        if (!nv && i_rst_n) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_items.size() > 0 && !(issued == PAUSE_AT && replies_due != 0)) begin
                it = pending_items.pop_front();
                s_axis_tdata <= {it.large_ticks, it.large_power, it.small_ticks,
                                 it.small_power, it.resp_check, it.resp_id};
                s_axis_tuser <= {it.load_large, it.load_small};
                issued++;
                nv = 1'b1;
            end
        end
        s_axis_tvalid <= nv;
    end

    // Receiver.
    always @(negedge i_clk) begin
        logic nr;
        if (replies_seen != rx_seen) begin
            rx_seen = replies_seen;
            if (rx_seen % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            rx_wait = rx_burst ? 0 : $urandom_range(0, 3);
        end
        if (!i_rst_n) begin
            nr = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end else if (!hold_done && replies_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            nr = 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            nr = 1'b0;
        end else begin
            nr = 1'b1;
        end
        m_axis_tready <= nr;
    end

    // Input side: every accepted item is predicted.
    always @(posedge i_clk) begin
        t_glsq_item it;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            it.resp_id = s_axis_tdata[7:0];
            it.resp_check = s_axis_tdata[15:8];
            it.small_power = s_axis_tdata[23:16];
            it.small_ticks = s_axis_tdata[31:24];
            it.large_power = s_axis_tdata[39:32];
            it.large_ticks = s_axis_tdata[47:40];
            it.load_small = s_axis_tuser[0];
            it.load_large = s_axis_tuser[1];
            predict_reply(it);
            taken++;
        end
    end

    // Output side: every accepted item is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_link_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            replies_seen++;
            if (expected_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item, expected none, actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = expected_replies.pop_front();
                replies_due--;
                check_field("frame_kind", want.frame, m_axis_tdata[2:0]);
                check_field("high_speed", want.fast, m_axis_tdata[3]);
                check_field("device_kind", want.dev, m_axis_tdata[6:4]);
                check_field("link_state", want.seq, m_axis_tdata[11:7]);
                check_field("motor_small_out", want.motor_small, m_axis_tdata[19:12]);
                check_field("motor_large_out", want.motor_large, m_axis_tdata[27:20]);
                check_field("zero fill", 0, m_axis_tdata[31:28]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_glsq_item it;
        logic [7:0] id;
        logic [7:0] chk;

        it = reply_item(8'h00, 8'h00);
        it.load_small = 1'b1;
        it.small_power = 8'hff;
        it.small_ticks = 8'h00;
        it.load_large = 1'b1;
        it.large_power = 8'hff;
        it.large_ticks = 8'hff;
        enqueue_reply(it);
        it = reply_item(8'hff, READY_BYTE);
        it.load_small = 1'b1;
        it.small_power = 8'h81;
        it.small_ticks = 8'h01;
        enqueue_reply(it);
        enqueue_reply(reply_item(8'h00, 8'hff));
        enqueue_reply(reply_item(ID_TWIST, READY_BYTE));
        enqueue_reply(reply_item(WORD_TWIST[7:0], WORD_TWIST[15:8]));
        it = reply_item(WORD_DIGITAL[7:0], WORD_DIGITAL[15:8]);
        it.load_large = 1'b1;
        enqueue_reply(it);
        enqueue_reply(reply_item(8'h12, READY_BYTE));
        enqueue_reply(reply_item(8'h34, READY_BYTE));
        enqueue_reply(reply_item(8'h56, READY_BYTE));
        enqueue_reply(reply_item(8'h78, READY_BYTE));
        enqueue_reply(reply_item(WORD_FTWIST[7:0], WORD_FTWIST[15:8]));
        enqueue_reply(reply_item(WORD_FTWIST[7:0], WORD_FTWIST[15:8]));
        enqueue_reply(reply_item(WORD_FTWIST[15:8], WORD_FTWIST[7:0]));
        enqueue_reply(reply_item(8'h9a, READY_BYTE));
        enqueue_reply(reply_item(8'h00, 8'h5b));
        enqueue_reply(reply_item(8'h00, READY_BYTE));
        enqueue_reply(reply_item(8'h00, 8'h00));
        enqueue_reply(reply_item(WORD_DIGITAL[7:0], WORD_DIGITAL[15:8]));
        enqueue_reply(reply_item(8'h40, READY_BYTE));
        enqueue_reply(reply_item(8'hbc, READY_BYTE));
        enqueue_reply(reply_item(8'hde, 8'ha5));
        enqueue_reply(reply_item(8'h01, READY_BYTE));
        enqueue_reply(reply_item(8'h02, READY_BYTE));
        enqueue_reply(reply_item(WORD_DIGITAL[7:0], WORD_DIGITAL[15:8]));
        enqueue_reply(reply_item(8'hff, 8'hff));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick_reply(plan_seq, id, chk);
            it = reply_item(id, chk);
            it.load_small = ($urandom_range(0, 3) == 0);
            it.small_power = 8'($urandom);
            it.small_ticks = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
            it.load_large = ($urandom_range(0, 3) == 0);
            it.large_power = 8'($urandom);
            it.large_ticks = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
            enqueue_reply(it);
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (taken != total_items || replies_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d pad replies and checked %0d result items, %0d mismatches.",
                 taken, replies_seen, errors);
        $display("The link passed through %0d of its 29 states.", $countones(states_seen));
        if (errors == 0 && replies_due == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[game_pad_link_sequencer_top.f]
rtl/glsq_pkg.sv
rtl/glsq_step.sv
rtl/game_pad_link_sequencer_top.sv
test/tb_game_pad_link_sequencer_top.sv
